// ===== rtl/eba_pkg.sv =====
// Package for the eight-bit ALU with flags: field widths, command codes and the flag word.
// No dependencies; used by eight_bit_alu_with_flags.
package eba_pkg;

    localparam int unsigned CMD_W    = 5;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned IN_W     = CMD_W + 2 * WORD_W + INDEX_W;
    localparam int unsigned OUT_W    = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 5'd0,
        CMD_ADC       = 5'd1,
        CMD_SUB       = 5'd2,
        CMD_SBC       = 5'd3,
        CMD_AND       = 5'd4,
        CMD_XOR       = 5'd5,
        CMD_OR        = 5'd6,
        CMD_INC       = 5'd7,
        CMD_DEC       = 5'd8,
        CMD_ADD16     = 5'd9,
        CMD_RLC       = 5'd10,
        CMD_RRC       = 5'd11,
        CMD_RL        = 5'd12,
        CMD_RR        = 5'd13,
        CMD_SLA       = 5'd14,
        CMD_SRA       = 5'd15,
        CMD_SWAP      = 5'd16,
        CMD_SRL       = 5'd17,
        CMD_BIT       = 5'd18,
        CMD_RES       = 5'd19,
        CMD_SET       = 5'd20,
        CMD_LOADFLAGS = 5'd21
    } cmd_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

// ===== rtl/eight_bit_alu_with_flags.sv =====
// Eight-bit CPU ALU with Z, N, H and C flags, an input register and a result register.
// Depends on eba_pkg for field widths, command codes and the flag word type.
//
// A request enters on the s_ group when s_tvalid and s_tready are both high. It carries a
// command, two 16-bit operands and a bit index. Each request gives exactly one result on the
// m_ group: the 16-bit result and all four flags as they stand after the command.
// A request is captured in the input register, computed in one pass of combinational logic
// and written to the result register, from which it is offered on the m_ group.
// One request is taken in every cycle while s_tready stays high; the only state carried from
// one request to the next is the flag register, which is updated when the result register is loaded.
// Reset clears the valid bits of both stages and all flags. When the receiver holds m_tready low, the result
// register keeps its value, the input register fills, and then s_tready falls until the
// result is taken.
module eight_bit_alu_with_flags (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: command[4:0], operand_a[15:0], operand_b[15:0], bit_index[2:0].
    input  logic [eba_pkg::IN_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: result[15:0], zero_flag, subtract_flag, half_carry_flag,
    // carry_flag, then zero fill.
    output logic [eba_pkg::OUT_W-1:0] m_tdata
);
    import eba_pkg::*;

    logic               in_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [WORD_W-1:0]  a_reg;
    logic [WORD_W-1:0]  b_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;
    flags_t             flags_reg;

    logic               out_free;
    logic               advance;
    logic [WORD_W-1:0]  result_next;
    flags_t             flags_next;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W:0]   sum9;
        logic [4:0]        nib5;
        logic [WORD_W:0]   sum17;
        logic [12:0]       sum13;
        logic              t;
        a           = a_reg[BYTE_W-1:0];
        b           = b_reg[BYTE_W-1:0];
        mask        = BYTE_W'(1) << idx_reg;
        t           = (cmd_reg == CMD_ADC || cmd_reg == CMD_SBC) ? flags_reg.c : 1'b0;
        sum9        = '0;
        nib5        = '0;
        sum17       = '0;
        sum13       = '0;
        r           = '0;
        result_next = '0;
        flags_next  = flags_reg;
        case (cmd_reg)
            CMD_ADD, CMD_ADC:
            begin
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
                r = sum9[BYTE_W-1:0];
                flags_next = '{z: (r == '0), n: 1'b0, h: nib5[4], c: sum9[BYTE_W]};
            end
            CMD_SUB, CMD_SBC:
            begin
                sum9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
                nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
                r = sum9[BYTE_W-1:0];
                flags_next = '{z: (r == '0), n: 1'b1, h: nib5[4], c: sum9[BYTE_W]};
            end
            CMD_AND:
            begin
                r = a & b;
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_XOR:
            begin
                r = a ^ b;
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_OR:
            begin
                r = a | b;
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC:
            begin
                r = a + 8'd1;
                flags_next = '{z: (r == '0), n: 1'b0, h: (a[3:0] == 4'hf), c: flags_reg.c};
            end
            CMD_DEC:
            begin
                r = a - 8'd1;
                flags_next = '{z: (r == '0), n: 1'b1, h: (a[3:0] == 4'h0), c: flags_reg.c};
            end
            CMD_RLC:
            begin
                r = {b[6:0], b[7]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[7]};
            end
            CMD_RRC:
            begin
                r = {b[0], b[7:1]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[0]};
            end
            CMD_RL:
            begin
                r = {b[6:0], flags_reg.c};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[7]};
            end
            CMD_RR:
            begin
                r = {flags_reg.c, b[7:1]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[0]};
            end
            CMD_SLA:
            begin
                r = {b[6:0], 1'b0};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[7]};
            end
            CMD_SRA:
            begin
                r = {b[7], b[7:1]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[0]};
            end
            CMD_SWAP:
            begin
                r = {b[3:0], b[7:4]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_SRL:
            begin
                r = {1'b0, b[7:1]};
                flags_next = '{z: (r == '0), n: 1'b0, h: 1'b0, c: b[0]};
            end
            CMD_BIT:
            begin
                r = b;
                flags_next = '{z: ((b & mask) == '0), n: 1'b0, h: 1'b1, c: flags_reg.c};
            end
            CMD_RES:
            begin
                r = b & ~mask;
            end
            CMD_SET:
            begin
                r = b | mask;
            end
            CMD_LOADFLAGS:
            begin
                flags_next = flags_t'(b_reg[3:0]);
            end
            default:
            begin
                r = '0;
            end
        endcase
        if (cmd_reg == CMD_ADD16)
        begin
            sum17 = {1'b0, a_reg} + {1'b0, b_reg};
            sum13 = {1'b0, a_reg[11:0]} + {1'b0, b_reg[11:0]};
            result_next = sum17[WORD_W-1:0];
            flags_next = '{z: flags_reg.z, n: 1'b0, h: sum13[12], c: sum17[WORD_W]};
        end
        else
        begin
            result_next = {{(WORD_W-BYTE_W){1'b0}}, r};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            a_reg   <= s_tdata[CMD_W +: WORD_W];
            b_reg   <= s_tdata[CMD_W + WORD_W +: WORD_W];
            idx_reg <= s_tdata[CMD_W + 2 * WORD_W +: INDEX_W];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - WORD_W - 4){1'b0}},
                       flags_reg.c, flags_reg.h, flags_reg.n, flags_reg.z, result_reg};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for eight_bit_alu_with_flags: directed and random ALU requests,
// with each result checked against a flag-tracking ALU predictor built into the bench.
// Depends on eba_pkg and the eight_bit_alu_with_flags RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
    localparam int unsigned TIMEOUT_NS = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        flags_t            flags;
    } alu_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    alu_result_t  expected_results[$];
    flags_t       alu_flags;
    int unsigned  error_count = 0;
    int unsigned  checked_count = 0;
    int unsigned  burst_left = 0;
    bit           tx_gaps = 1'b0;
    bit           rx_stalls = 1'b0;

    eight_bit_alu_with_flags DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic flags_t byte_flags(input logic [7:0] r, input logic sub,
                                          input logic half, input logic carry);
        return '{z: (r == 8'h00), n: sub, h: half, c: carry};
    endfunction

    function automatic alu_result_t compute_alu(input logic [CMD_W-1:0] code,
                                                input logic [WORD_W-1:0] op_a,
                                                input logic [WORD_W-1:0] op_b,
                                                input logic [INDEX_W-1:0] index,
                                                input flags_t prev);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r;
        logic [7:0]  mask;
        logic [8:0]  wide;
        logic [4:0]  nibble;
        logic [12:0] low12;
        logic [16:0] wide16;
        logic        ci;
        alu_result_t out;
        a = op_a[7:0];
        b = op_b[7:0];
        mask = 8'h01 << index;
        r = '0;
        out.flags = prev;
        ci = 1'b0;
        case (code)
            CMD_ADD, CMD_ADC:
            begin
                ci = (code == CMD_ADC) && prev.c;
                wide = {1'b0, a} + b + ci;
                nibble = {1'b0, a[3:0]} + b[3:0] + ci;
                r = wide[7:0];
                out.flags = byte_flags(r, 1'b0, nibble[4], wide[8]);
            end
            CMD_SUB, CMD_SBC:
            begin
                ci = (code == CMD_SBC) && prev.c;
                wide = {1'b0, a} - b - ci;
                nibble = {1'b0, a[3:0]} - b[3:0] - ci;
                r = wide[7:0];
                out.flags = byte_flags(r, 1'b1, nibble[4], wide[8]);
            end
            CMD_AND:
            begin
                r = a & b;
                out.flags = byte_flags(r, 1'b0, 1'b1, 1'b0);
            end
            CMD_XOR:
            begin
                r = a ^ b;
                out.flags = byte_flags(r, 1'b0, 1'b0, 1'b0);
            end
            CMD_OR:
            begin
                r = a | b;
                out.flags = byte_flags(r, 1'b0, 1'b0, 1'b0);
            end
            CMD_INC:
            begin
                r = a + 8'h01;
                out.flags = byte_flags(r, 1'b0, a[3:0] == 4'hF, prev.c);
            end
            CMD_DEC:
            begin
                r = a - 8'h01;
                out.flags = byte_flags(r, 1'b1, a[3:0] == 4'h0, prev.c);
            end
            CMD_ADD16:
            begin
                wide16 = {1'b0, op_a} + op_b;
                low12 = {1'b0, op_a[11:0]} + op_b[11:0];
                out.flags = '{z: prev.z, n: 1'b0, h: low12[12], c: wide16[16]};
            end
            CMD_RLC:
            begin
                r = {b[6:0], b[7]};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[7]);
            end
            CMD_RRC:
            begin
                r = {b[0], b[7:1]};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[0]);
            end
            CMD_RL:
            begin
                r = {b[6:0], prev.c};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[7]);
            end
            CMD_RR:
            begin
                r = {prev.c, b[7:1]};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[0]);
            end
            CMD_SLA:
            begin
                r = {b[6:0], 1'b0};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[7]);
            end
            CMD_SRA:
            begin
                r = {b[7], b[7:1]};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[0]);
            end
            CMD_SWAP:
            begin
                r = {b[3:0], b[7:4]};
                out.flags = byte_flags(r, 1'b0, 1'b0, 1'b0);
            end
            CMD_SRL:
            begin
                r = {1'b0, b[7:1]};
                out.flags = byte_flags(r, 1'b0, 1'b0, b[0]);
            end
            CMD_BIT:
            begin
                r = b;
                out.flags = '{z: (b & mask) == 8'h00, n: 1'b0, h: 1'b1, c: prev.c};
            end
            CMD_RES:
                r = b & ~mask;
            CMD_SET:
                r = b | mask;
            CMD_LOADFLAGS:
                out.flags = flags_t'(op_b[3:0]);
            default:
                r = '0;
        endcase
        out.value = (code == CMD_ADD16) ? wide16[15:0] : {8'h00, r};
        return out;
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        error_count++;
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $realtime, checked_count, field, want, got);
    endtask

    // Requests are predicted when accepted; results are checked in order.
    always @(posedge clk)
    begin : result_check
        alu_result_t want;
        flags_t      got_flags;
        if (rst_n && s_tvalid && s_tready)
        begin
            want = compute_alu(s_tdata[4:0], s_tdata[20:5], s_tdata[36:21],
                               s_tdata[39:37], alu_flags);
            alu_flags = want.flags;
            expected_results.push_back(want);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got_flags = flags_t'({m_tdata[16], m_tdata[17], m_tdata[18], m_tdata[19]});
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("[%0t] result 0x%0h arrived with no request pending",
                         $realtime, m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.value)
                    report_mismatch("result", want.value, m_tdata[15:0]);
                if (got_flags.z !== want.flags.z)
                    report_mismatch("zero_flag", WORD_W'(want.flags.z), WORD_W'(got_flags.z));
                if (got_flags.n !== want.flags.n)
                    report_mismatch("subtract_flag", WORD_W'(want.flags.n),
                                    WORD_W'(got_flags.n));
                if (got_flags.h !== want.flags.h)
                    report_mismatch("half_carry_flag", WORD_W'(want.flags.h),
                                    WORD_W'(got_flags.h));
                if (got_flags.c !== want.flags.c)
                    report_mismatch("carry_flag", WORD_W'(want.flags.c), WORD_W'(got_flags.c));
            end
            checked_count++;
        end
    end

    initial
    begin : receiver
        logic [15:0] ready_pattern;
        int unsigned step;
        m_tready = 1'b0;
        ready_pattern = '1;
        step = 0;
        forever
        begin
            @(negedge clk);
            if (!rx_stalls)
                m_tready <= 1'b1;
            else
            begin
                if (step % 48 == 0)
                    ready_pattern = ($urandom_range(0, 1) ? 16'($urandom())
                                    : 16'($urandom() & $urandom())) | 16'h0001;
                m_tready <= ready_pattern[step % 16];
            end
            step++;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] code, input logic [WORD_W-1:0] op_a,
                                input logic [WORD_W-1:0] op_b,
                                input logic [INDEX_W-1:0] index);
        int unsigned gap;
        @(negedge clk);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {index, op_b, op_a, code};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [WORD_W-1:0] pick_operand();
        logic [WORD_W-1:0] w;
        w = 16'($urandom());
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w[7:0] = 8'h00;
            3: w[7:0] = 8'hFF;
            4: w[3:0] = 4'hF;
            5: w[11:0] = 12'hFFF;
            default: ;
        endcase
        return w;
    endfunction

    task automatic test_add_sub();
        send_request(CMD_LOADFLAGS, 16'h0000, 16'hFFFF, 3'd0);
        send_request(CMD_ADC, 16'hFFFF, 16'hFFFF, 3'd0);
        send_request(CMD_SBC, 16'h0000, 16'h00FF, 3'd0);
        send_request(CMD_ADD, 16'h0000, 16'h0000, 3'd0);
        send_request(CMD_SUB, 16'hAB34, 16'h1234, 3'd0);
    endtask

    task automatic test_logic_ops();
        send_request(CMD_AND, 16'hABCD, 16'h00F0, 3'd0);
        send_request(CMD_XOR, 16'h5A5A, 16'hA55A, 3'd0);
        send_request(CMD_OR, 16'hFF00, 16'h0000, 3'd0);
    endtask

    task automatic test_inc_dec();
        send_request(CMD_INC, 16'h12FF, 16'h0000, 3'd0);
        send_request(CMD_DEC, 16'h0000, 16'hFFFF, 3'd0);
    endtask

    task automatic test_add16();
        send_request(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0);
        send_request(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0);
    endtask

    task automatic test_shifts();
        send_request(CMD_RLC, 16'h0000, 16'h0080, 3'd0);
        send_request(CMD_RRC, 16'h0000, 16'h0001, 3'd0);
        send_request(CMD_RL, 16'h0000, 16'h0080, 3'd0);
        send_request(CMD_RR, 16'h0000, 16'hFF01, 3'd0);
        send_request(CMD_SLA, 16'h0000, 16'h00FF, 3'd0);
        send_request(CMD_SRA, 16'h0000, 16'h0080, 3'd0);
        send_request(CMD_SWAP, 16'h0000, 16'h00F0, 3'd0);
        send_request(CMD_SRL, 16'h0000, 16'h0001, 3'd0);
    endtask

    task automatic test_bit_ops();
        send_request(CMD_BIT, 16'h0000, 16'h0080, 3'd7);
        send_request(CMD_BIT, 16'h0000, 16'hFF00, 3'd0);
        send_request(CMD_RES, 16'h0000, 16'hFFFF, 3'd7);
        send_request(CMD_SET, 16'hFFFF, 16'h0000, 3'd0);
    endtask

    task automatic test_unused_codes();
        send_request(CMD_LAST_CODE, 16'hFFFF, 16'hFFFF, 3'd7);
        send_request(CMD_W'(CMD_LOADFLAGS + 1), 16'h1234, 16'h5678, 3'd3);
    endtask

    task automatic test_random_ops(input int unsigned count);
        logic [CMD_W-1:0] code;
        repeat (count)
        begin
            if ($urandom_range(0, 31) == 0)
                code = CMD_W'($urandom_range(CMD_LOADFLAGS + 1, CMD_LAST_CODE));
            else
                code = CMD_W'($urandom_range(CMD_ADD, CMD_LOADFLAGS));
            send_request(code, pick_operand(), pick_operand(), INDEX_W'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        alu_flags = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_add_sub();
        test_logic_ops();
        test_inc_dec();
        test_add16();
        test_shifts();
        test_bit_ops();
        test_unused_codes();

        test_random_ops(300);
        tx_gaps = 1'b1;
        test_random_ops(450);
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        test_random_ops(450);
        tx_gaps = 1'b1;
        test_random_ops(625);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("eight_bit_alu_with_flags test passed");
        else
            $display("eight_bit_alu_with_flags test failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[%0t] timeout with %0d results outstanding", $realtime,
                 expected_results.size());
        $display("eight_bit_alu_with_flags test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/eba_pkg.sv
rtl/eight_bit_alu_with_flags.sv
tb/tb_top.sv
